[hdl/rect_to_polar_converter_assert.svh]
// Assertion macros shared by the checker of the rectangular to polar converter.
// Each macro samples on clk_i and is switched off while rst_ni is low.
`ifndef RECT_TO_POLAR_CONVERTER_ASSERT_SVH
`define RECT_TO_POLAR_CONVERTER_ASSERT_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define R2P_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("r2p: same-cycle check failed");

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define R2P_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("r2p: next-cycle check failed");

`endif

[hdl/r2p_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, the arctangent table and the per-cell data word of the
// rectangular to polar converter. Used by every module of the block.
package r2p_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int ITERATIONS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MAG_W        = 16;
  localparam int PHASE_W      = 16;
  localparam int ANGLE_W      = 32;

  // Micro-rotations are capped at the table length.
  localparam int CORDIC_STEPS = (ITERATIONS < 32) ? ITERATIONS : 32;
  // One root digit per cell, two radicand bits per digit.
  localparam int SQRT_STEPS   = DATA_WIDTH;
  localparam int NUM_CELLS    = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int IDX_W        = $clog2(NUM_CELLS);

  // Vector width: input plus fraction bits plus headroom for the CORDIC gain.
  localparam int CW           = DATA_WIDTH + FRAC_BITS + 3;
  localparam int RAD_W        = 2 * DATA_WIDTH;
  localparam int REM_W        = DATA_WIDTH + 2;
  localparam int MAGX_W       = (DATA_WIDTH + 1 > MAG_W + 1) ? DATA_WIDTH + 1 : MAG_W + 1;

  localparam logic [MAG_W-1:0]   MAG_MAX   = '1;
  localparam logic [ANGLE_W-1:0] PI_ANGLE  = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] PH_ROUND  = 32'h0000_8000;

  // atan(2^-i) with 2^31 standing for pi, rounded to nearest.
  localparam logic [ANGLE_W-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Data word handed from one cell to the next.
  typedef struct packed {
    logic                    zero;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic [ANGLE_W-1:0]      z;
    logic [RAD_W-1:0]        rad;
    logic [REM_W-1:0]        rem;
    logic [DATA_WIDTH-1:0]   root;
  } cell_data_t;

  function automatic logic [ANGLE_W-1:0] atan_lookup(input logic [4:0] idx);
    return ATAN_TAB[idx];
  endfunction

endpackage

[hdl/r2p_prep.sv]
`timescale 1ns / 1ps
// Front end of the converter: squares the inputs, sums them and folds the
// vector into the right half plane. Two register stages; depends on r2p_pkg.
module r2p_prep (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] re_part_i,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] im_part_i,
  output logic                                  valid_o,
  output r2p_pkg::cell_data_t                   data_o
);

  logic signed [r2p_pkg::RAD_W-1:0] sq_re_d, sq_im_d;
  logic [r2p_pkg::RAD_W-1:0]        sq_re_q, sq_im_q;
  logic signed [r2p_pkg::CW-1:0]    re_ext, im_ext;
  logic signed [r2p_pkg::CW-1:0]    x_d, y_d, x_q, y_q;
  logic [r2p_pkg::ANGLE_W-1:0]      z_d, z_q;
  logic                             zero_d, zero_q;
  logic                             v1_q, v2_q;
  r2p_pkg::cell_data_t              data_d, data_q;

  // First stage: squares, fixed-point vector and half-plane fold.
  always_comb begin
    sq_re_d = r2p_pkg::RAD_W'(re_part_i) * r2p_pkg::RAD_W'(re_part_i);
    sq_im_d = r2p_pkg::RAD_W'(im_part_i) * r2p_pkg::RAD_W'(im_part_i);
    re_ext  = r2p_pkg::CW'(re_part_i);
    im_ext  = r2p_pkg::CW'(im_part_i);
    x_d     = re_ext <<< r2p_pkg::FRAC_BITS;
    y_d     = im_ext <<< r2p_pkg::FRAC_BITS;
    z_d     = '0;
    zero_d  = (re_part_i == '0) && (im_part_i == '0);
    if (re_part_i[r2p_pkg::DATA_WIDTH-1]) begin
      x_d = -x_d;
      y_d = -y_d;
      z_d = r2p_pkg::PI_ANGLE;
    end
  end

  // Second stage: radicand is the sum of the squares.
  always_comb begin
    data_d      = '0;
    data_d.zero = zero_q;
    data_d.x    = x_q;
    data_d.y    = y_q;
    data_d.z    = z_q;
    data_d.rad  = sq_re_q + sq_im_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_re_q <= sq_re_d;
      sq_im_q <= sq_im_d;
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      zero_q  <= zero_d;
      data_q  <= data_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

endmodule

[hdl/r2p_cell.sv]
`timescale 1ns / 1ps
// One cell of the converter chain: a CORDIC micro-rotation and one digit of
// the integer square root, registered. Depends on r2p_pkg.
module r2p_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [r2p_pkg::IDX_W-1:0]  idx_i,
  input  logic                       valid_i,
  input  r2p_pkg::cell_data_t        data_i,
  output logic                       valid_o,
  output r2p_pkg::cell_data_t        data_o
);

  localparam int DW = r2p_pkg::DATA_WIDTH;

  logic                          do_rot, do_sqrt;
  logic signed [r2p_pkg::CW-1:0] xs, ys;
  logic [r2p_pkg::ANGLE_W-1:0]   atan_v;
  logic [r2p_pkg::REM_W-1:0]     rem_sh, trial;
  logic                          valid_q;
  r2p_pkg::cell_data_t           data_d, data_q;

  // Which of the two jobs this position of the chain carries out.
  assign do_rot  = 32'(idx_i) < r2p_pkg::CORDIC_STEPS;
  assign do_sqrt = 32'(idx_i) < r2p_pkg::SQRT_STEPS;

  // Micro-rotation towards the real axis and one restoring root digit.
  always_comb begin
    xs     = data_i.x >>> idx_i;
    ys     = data_i.y >>> idx_i;
    atan_v = r2p_pkg::atan_lookup(5'(idx_i));
    rem_sh = {data_i.rem[DW-1:0], data_i.rad[r2p_pkg::RAD_W-1 -: 2]};
    trial  = {data_i.root, 2'b01};
    data_d = data_i;
    if (do_rot) begin
      if (!data_i.y[r2p_pkg::CW-1]) begin
        data_d.x = data_i.x + ys;
        data_d.y = data_i.y - xs;
        data_d.z = data_i.z + atan_v;
      end else begin
        data_d.x = data_i.x - ys;
        data_d.y = data_i.y + xs;
        data_d.z = data_i.z - atan_v;
      end
    end
    if (do_sqrt) begin
      data_d.rad = data_i.rad << 2;
      if (rem_sh >= trial) begin
        data_d.rem  = rem_sh - trial;
        data_d.root = {data_i.root[DW-2:0], 1'b1};
      end else begin
        data_d.rem  = rem_sh;
        data_d.root = {data_i.root[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hdl/rect_to_polar_converter.sv]
`timescale 1ns / 1ps
// Top level of the rectangular to polar converter: front end, a chain of
// identical cells and the output register. Depends on r2p_pkg, r2p_prep, r2p_cell.
//
//   Channel  Handshake                 Word
//   in       in_valid_i / in_stall_o   re_part_i, im_part_i (signed)
//   out      out_valid_o / out_stall_i magnitude_o (unsigned), phase_o (signed)
//
// One word is taken every cycle while the output is not stalled. Each word passes
// two front-end stages, one cell per CORDIC micro-rotation and root digit,
// and the output register.
// Reset clears the valid bits of every stage; there is no clearing pass.
// A stalled output word freezes the whole chain, so in_stall_o follows it.
module rect_to_polar_converter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] re_part_i,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] im_part_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [r2p_pkg::MAG_W-1:0]             magnitude_o,
  output logic signed [r2p_pkg::PHASE_W-1:0]    phase_o
);

  localparam int N = r2p_pkg::NUM_CELLS;

  logic                          adv;
  logic                          chain_valid [N+1];
  r2p_pkg::cell_data_t           chain_data  [N+1];
  r2p_pkg::cell_data_t           last;
  logic                          round_up;
  logic [r2p_pkg::MAGX_W-1:0]    mag_ext;
  logic [r2p_pkg::ANGLE_W-1:0]   z_rnd;
  logic [r2p_pkg::MAG_W-1:0]     mag_d, mag_q;
  logic [r2p_pkg::PHASE_W-1:0]   phase_d, phase_q;
  logic                          out_valid_q;

  // The chain moves whenever the output register can take a word.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign adv        = !in_stall_o;

  r2p_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (in_valid_i),
    .re_part_i (re_part_i),
    .im_part_i (im_part_i),
    .valid_o   (chain_valid[0]),
    .data_o    (chain_data[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    r2p_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .idx_i   (r2p_pkg::IDX_W'(g)),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // Round the root to nearest, saturate, and round the angle to 16 bits.
  always_comb begin
    last     = chain_data[N];
    round_up = last.rem > r2p_pkg::REM_W'(last.root);
    mag_ext  = r2p_pkg::MAGX_W'(last.root) + r2p_pkg::MAGX_W'(round_up);
    z_rnd    = last.z + r2p_pkg::PH_ROUND;
    if (mag_ext > r2p_pkg::MAGX_W'(r2p_pkg::MAG_MAX)) begin
      mag_d = r2p_pkg::MAG_MAX;
    end else begin
      mag_d = mag_ext[r2p_pkg::MAG_W-1:0];
    end
    if (last.zero) begin
      phase_d = '0;
    end else begin
      phase_d = z_rnd[r2p_pkg::ANGLE_W-1 -: r2p_pkg::PHASE_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain_valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && chain_valid[N]) begin
      mag_q   <= mag_d;
      phase_q <= phase_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign phase_o     = phase_q;

endmodule

[hdl/r2p_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the rectangular to polar converter, bound to the top
// level. Depends on r2p_pkg and rect_to_polar_converter_assert.svh.
`include "rect_to_polar_converter_assert.svh"

module r2p_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic signed [r2p_pkg::DATA_WIDTH-1:0] re_part_i,
  input logic signed [r2p_pkg::DATA_WIDTH-1:0] im_part_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic [r2p_pkg::MAG_W-1:0]             magnitude_o,
  input logic signed [r2p_pkg::PHASE_W-1:0]    phase_o
);

  // A stalled output word stays offered.
  `R2P_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // The input side is held back only by a waiting output word.
  `R2P_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // A waiting output word always holds the input side back.
  `R2P_ASSERT_IMP(a_stall_pass, out_valid_o && out_stall_i, in_stall_o)

  // A stalled output word keeps its value.
  `R2P_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i,
                  $stable(magnitude_o) && $stable(phase_o))

  // A stalled input word stays offered and keeps its value.
  `R2P_ASSERT_NXT(a_in_stable, in_valid_i && in_stall_o,
                  in_valid_i && $stable(re_part_i) && $stable(im_part_i))

endmodule

bind rect_to_polar_converter r2p_chk u_r2p_chk (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the rectangular to polar converter: directed corner vectors,
// then random samples, with an exact-integer root and CORDIC predictor.
// Depends on r2p_pkg and rect_to_polar_converter.
module testbench;

  localparam int DW            = r2p_pkg::DATA_WIDTH;
  localparam int ROT_COUNT     = (r2p_pkg::ITERATIONS < 32) ? r2p_pkg::ITERATIONS : 32;
  localparam int RANDOM_WORDS  = 1850;
  localparam int IDLE_PERCENT  = 24;
  localparam int CALM_FROM     = 1200;
  localparam int CALM_TO       = 1800;
  localparam int DRAIN_CYCLES  = 60;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int TOLERANCE_LSB = 2;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // Arctangent of 2^-i, with 2^31 standing for pi.
  localparam logic [31:0] ARCTAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
  } rect_t;

  typedef struct packed {
    logic [r2p_pkg::MAG_W-1:0]          magnitude;
    logic signed [r2p_pkg::PHASE_W-1:0] phase;
  } polar_t;

  logic                                  clk_i       = 1'b0;
  logic                                  rst_ni      = 1'b0;
  logic                                  in_valid_i  = 1'b0;
  logic                                  in_stall_o;
  logic signed [DW-1:0]                  re_part_i   = '0;
  logic signed [DW-1:0]                  im_part_i   = '0;
  logic                                  out_valid_o;
  logic                                  out_stall_i = 1'b0;
  logic [r2p_pkg::MAG_W-1:0]             magnitude_o;
  logic signed [r2p_pkg::PHASE_W-1:0]    phase_o;

  rect_t  pending_rect[$];
  polar_t expected_polar[$];
  int     cycle_count   = 0;
  int     words_sent    = 0;
  int     words_checked = 0;
  int     failures      = 0;

  rect_to_polar_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .re_part_i  (re_part_i),
    .im_part_i  (im_part_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .magnitude_o(magnitude_o),
    .phase_o    (phase_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Random idle decision, suppressed over one calm stretch of the run.
  function automatic bit take_break();
    if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PERCENT;
  endfunction

  // Rounded radius from an exact integer root, and the phase from CORDIC vectoring.
  function automatic polar_t predict_polar(input logic signed [DW-1:0] re,
                                           input logic signed [DW-1:0] im);
    polar_t            res;
    longint unsigned   radicand;
    longint unsigned   root;
    longint unsigned   trial;
    longint signed     x;
    longint signed     y;
    longint signed     dx;
    longint signed     dy;
    logic [31:0]       angle;
    logic [31:0]       rounded;
    res = '0;
    if (re == 0 && im == 0) return res;
    radicand = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    // Build the floor root one bit at a time, then round to nearest.
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    if (radicand - root * root > root) root++;
    res.magnitude = (root > 65535) ? 16'hFFFF : root[15:0];
    // Vectors in the left half plane are turned by pi first.
    x = longint'(re) * 65536;
    y = longint'(im) * 65536;
    angle = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      angle = HALF_TURN;
    end
    for (int i = 0; i < ROT_COUNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        angle = angle + ARCTAN_STEP[i];
      end else begin
        x = x - dx;
        y = y + dy;
        angle = angle - ARCTAN_STEP[i];
      end
    end
    rounded = angle + 32'h0000_8000;
    res.phase = rounded[31:16];
    return res;
  endfunction

  // Driver: presents queued words and records the prediction of each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    rect_t upcoming;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_polar.push_back(predict_polar(re_part_i, im_part_i));
        words_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_rect.size() > 0 && !take_break()) begin
          upcoming = pending_rect.pop_front();
          re_part_i  <= upcoming.re;
          im_part_i  <= upcoming.im;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and comparison against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : check_words
    polar_t                want;
    int                    mag_gap;
    logic signed [15:0]    phase_gap;
    int                    phase_dist;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_polar.size() == 0) begin
          $error("unexpected word: magnitude %0d phase %0d", magnitude_o, phase_o);
          failures++;
        end else begin
          want = expected_polar.pop_front();
          words_checked++;
          // Fixed-point hardware may differ from the prediction by a couple of LSB.
          mag_gap = int'(magnitude_o) - int'(want.magnitude);
          if (mag_gap > TOLERANCE_LSB || mag_gap < -TOLERANCE_LSB) begin
            $error("magnitude: expected %0d, actual %0d", want.magnitude, magnitude_o);
            failures++;
          end
          // The phase wraps, so its distance is taken modulo a full turn.
          phase_gap  = phase_o - want.phase;
          phase_dist = (phase_gap < 0) ? -int'(phase_gap) : int'(phase_gap);
          if (phase_dist > TOLERANCE_LSB) begin
            $error("phase: expected %0d, actual %0d", want.phase, phase_o);
            failures++;
          end
        end
      end
      out_stall_i <= take_break();
    end
  end

  task automatic add_word(input int re, input int im);
    rect_t w;
    w.re = re[DW-1:0];
    w.im = im[DW-1:0];
    pending_rect.push_back(w);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(4))
      0: return -32768;
      1: return -32767;
      2: return 32767;
      3: return 0;
      default: return $urandom_range(65535) - 32768;
    endcase
  endfunction

  // Stimulus, reset and end of run.
  initial begin : run_test
    int a;
    int b;
    // Zero vector, the four axes and their extremes.
    add_word(0, 0);
    add_word(1, 0);
    add_word(-1, 0);
    add_word(0, 1);
    add_word(0, -1);
    add_word(32767, 0);
    add_word(-32768, 0);
    add_word(0, 32767);
    add_word(0, -32768);
    // Corners of the input range, giving the largest radius.
    add_word(-32768, -32768);
    add_word(32767, 32767);
    add_word(-32768, 32767);
    add_word(32767, -32768);
    // Just either side of the negative real axis, where the phase wraps, then the four unit diagonals.
    add_word(-32768, 1);
    add_word(-32768, -1);
    add_word(-1, -1);
    add_word(-1, 1);
    add_word(1, -1);
    add_word(1, 1);
    // Negative imaginary part with a positive real part, and mixed diagonals.
    add_word(1000, -2000);
    add_word(-12345, 23456);
    add_word(3, 4);
    add_word(-3, -4);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      case ($urandom_range(99)) inside
        [0:59]: begin
          a = $urandom_range(65535) - 32768;
          b = $urandom_range(65535) - 32768;
        end
        [60:74]: begin
          a = $urandom_range(16) - 8;
          b = $urandom_range(16) - 8;
        end
        [75:84]: begin
          a = $urandom_range(65535) - 32768;
          b = $urandom_range(6) - 3;
          if ($urandom_range(1)) begin
            b = a;
            a = $urandom_range(6) - 3;
          end
        end
        [85:94]: begin
          a = pick_extreme();
          b = pick_extreme();
        end
        default: begin
          a = $urandom_range(65535) - 32768;
          b = $urandom_range(1) ? a : -a;
        end
      endcase
      add_word(a, b);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_rect.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_polar.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_polar.size() > 0) begin
      $error("%0d predicted words never arrived", expected_polar.size());
      failures++;
    end
    $display("Converted %0d samples (zero vector, axes, range corners, all quadrants);",
             words_sent);
    $display("%0d polar words checked, %0d mismatches.", words_checked, failures);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
